### rtl/spte_pkg.sv
// ----------------------------------------------------------------------------
// spte_pkg
// Shared types and codes for the servo packet transaction engine.
// ----------------------------------------------------------------------------
package spte_pkg;

	// request types
	localparam logic [1:0] REQ_CMD  = 2'd0;
	localparam logic [1:0] REQ_RX   = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// result kinds
	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// completion status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TIMEOUT   = 2'd1;
	localparam logic [1:0] ST_SERVO_ERR = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_ID     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

	// reset values of the configuration registers
	localparam logic [7:0]  SERVO_ID_RST = 8'd1;
	localparam logic [15:0] TIMEOUT_RST  = 16'd100;

	// status packet length limits
	localparam logic [3:0] RESP_MIN       = 4'd6;
	localparam logic [3:0] MAX_RESP_BYTES = 4'd8;

	// one job handed from the front to the back
	typedef struct packed {
		logic        kind;
		logic [7:0]  id;
		logic [7:0]  instr;
		logic [7:0]  addr;
		logic        two_val;
		logic [15:0] value;
		logic [7:0]  chk;
		logic [1:0]  status;
		logic [15:0] read_value;
		logic [7:0]  servo_error;
	} job_t;

endpackage

### rtl/spte_req_if.sv
// ----------------------------------------------------------------------------
// spte_req_if
// Request channel: commands, received bus bytes and ticks.
// ----------------------------------------------------------------------------
interface spte_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  instr_code;
	logic [7:0]  reg_addr;
	logic [1:0]  value_bytes;
	logic [15:0] param_value;
	logic [3:0]  resp_len;
	logic [7:0]  rx_byte;

	modport source (
		output valid, req_type, instr_code, reg_addr, value_bytes, param_value,
		       resp_len, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, instr_code, reg_addr, value_bytes, param_value,
		       resp_len, rx_byte,
		output ready
	);
endinterface

### rtl/spte_rsp_if.sv
// ----------------------------------------------------------------------------
// spte_rsp_if
// Result channel: transmit bytes and transaction completions.
// ----------------------------------------------------------------------------
interface spte_rsp_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic [1:0]  status_code;
	logic [15:0] read_value;
	logic [7:0]  servo_error;

	modport source (
		output valid, out_kind, tx_byte, tx_last, status_code, read_value,
		       servo_error,
		input  ready
	);
	modport sink (
		input  valid, out_kind, tx_byte, tx_last, status_code, read_value,
		       servo_error,
		output ready
	);
endinterface

### rtl/spte_cfg_if.sv
// ----------------------------------------------------------------------------
// spte_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spte_cfg_if import spte_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/spte_front.sv
// ----------------------------------------------------------------------------
// spte_front
// Accepts request words, keeps the transaction state and configuration,
// and classifies each word into a transmit job, a completion job or nothing.
// ----------------------------------------------------------------------------
module spte_front import spte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	spte_req_if.sink  req,
	spte_cfg_if.sink  cfg,
	output logic      push_valid,
	output job_t      push_job,
	input  logic      push_ready
);

	// status packet byte positions
	localparam logic [3:0] RX_ERR_POS     = 4'd4;
	localparam logic [3:0] RX_DATA_LO_POS = 4'd5;
	localparam logic [3:0] RX_DATA_HI_POS = 4'd6;
	localparam logic [7:0] LEN_BASE       = 8'd3;

	logic [7:0]  servo_id_q;
	logic [15:0] timeout_q;
	logic        waiting_q;
	logic [3:0]  rx_count_q;
	logic [3:0]  expected_q;
	logic [7:0]  error_q;
	logic [7:0]  data_lo_q;
	logic [7:0]  data_hi_q;
	logic [15:0] elapsed_q;

	logic        waiting_d;
	logic [3:0]  rx_count_d;
	logic [3:0]  expected_d;
	logic [7:0]  error_d;
	logic [7:0]  data_lo_d;
	logic [7:0]  data_hi_d;
	logic [15:0] elapsed_d;

	logic        req_fire;
	logic        two_val;
	logic [7:0]  len_byte;
	logic [7:0]  sum;
	logic [3:0]  exp_clamp;
	logic [3:0]  rx_next;
	logic [15:0] elapsed_inc;

	assign req.ready = push_ready;
	assign req_fire  = req.valid & req.ready;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_id_q <= SERVO_ID_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SERVO_ID:      servo_id_q <= cfg.data[7:0];
				REG_TIMEOUT_TICKS: timeout_q  <= cfg.data;
				default:           ;
			endcase
		end
	end

	// packet fields and checksum
	assign two_val  = req.value_bytes[1];
	assign len_byte = LEN_BASE + (two_val ? 8'd2 : 8'd1);
	assign sum      = servo_id_q + len_byte + req.instr_code + req.reg_addr
	                + req.param_value[7:0] + (two_val ? req.param_value[15:8] : 8'd0);

	// reply length clamp
	always_comb begin
		if (req.resp_len < RESP_MIN)
			exp_clamp = RESP_MIN;
		else if (req.resp_len > MAX_RESP_BYTES)
			exp_clamp = MAX_RESP_BYTES;
		else
			exp_clamp = req.resp_len;
	end

	assign rx_next     = rx_count_q + 4'd1;
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	// next state and job classification
	always_comb begin
		waiting_d  = waiting_q;
		rx_count_d = rx_count_q;
		expected_d = expected_q;
		error_d    = error_q;
		data_lo_d  = data_lo_q;
		data_hi_d  = data_hi_q;
		elapsed_d  = elapsed_q;
		push_valid = 1'b0;
		push_job   = '0;
		if (req.valid) begin
			unique case (req.req_type)
				REQ_CMD: begin
					waiting_d          = 1'b1;
					rx_count_d         = 4'd0;
					expected_d         = exp_clamp;
					error_d            = 8'd0;
					data_lo_d          = 8'd0;
					data_hi_d          = 8'd0;
					elapsed_d          = 16'd0;
					push_valid         = 1'b1;
					push_job.kind      = KIND_TX;
					push_job.id        = servo_id_q;
					push_job.instr     = req.instr_code;
					push_job.addr      = req.reg_addr;
					push_job.two_val   = two_val;
					push_job.value     = req.param_value;
					push_job.chk       = ~sum;
				end
				REQ_RX: begin
					if (waiting_q) begin
						if (rx_count_q == RX_ERR_POS)
							error_d = req.rx_byte;
						else if (rx_count_q == RX_DATA_LO_POS)
							data_lo_d = req.rx_byte;
						else if (rx_count_q == RX_DATA_HI_POS)
							data_hi_d = req.rx_byte;
						rx_count_d = rx_next;
						if (rx_next >= expected_q) begin
							waiting_d            = 1'b0;
							push_valid           = 1'b1;
							push_job.kind        = KIND_DONE;
							push_job.status      = (error_d != 8'd0) ? ST_SERVO_ERR : ST_OK;
							push_job.read_value  = {data_hi_d, data_lo_d};
							push_job.servo_error = error_d;
						end
					end
				end
				REQ_TICK: begin
					if (waiting_q) begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc > timeout_q) begin
							waiting_d            = 1'b0;
							push_valid           = 1'b1;
							push_job.kind        = KIND_DONE;
							push_job.status      = ST_TIMEOUT;
							push_job.read_value  = {data_hi_q, data_lo_q};
							push_job.servo_error = error_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q  <= 1'b0;
			rx_count_q <= 4'd0;
			expected_q <= 4'd0;
			error_q    <= 8'd0;
			data_lo_q  <= 8'd0;
			data_hi_q  <= 8'd0;
			elapsed_q  <= 16'd0;
		end else if (req_fire) begin
			waiting_q  <= waiting_d;
			rx_count_q <= rx_count_d;
			expected_q <= expected_d;
			error_q    <= error_d;
			data_lo_q  <= data_lo_d;
			data_hi_q  <= data_hi_d;
			elapsed_q  <= elapsed_d;
		end
	end

`ifndef NO_ASSERTIONS
	// a transaction only ends together with a completion job
	a_end_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(waiting_q) |-> $past(req_fire && push_valid && push_job.kind == KIND_DONE))
		else $error("transaction ended without a completion");
`endif

endmodule

### rtl/spte_queue.sv
// ----------------------------------------------------------------------------
// spte_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module spte_queue import spte_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  job_t push_job,
	output logic push_ready,
	output logic pop_valid,
	output job_t pop_job,
	input  logic pop_ready
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push_fire  = push_valid & push_ready;
	assign pop_fire   = pop_valid & pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push_fire)
			mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_fire)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push_fire && !pop_fire)
				count_q <= count_q + 1'b1;
			else if (pop_fire && !push_fire)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

	// an empty queue has its pointers together
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("queue pointers apart while empty");
`endif

endmodule

### rtl/spte_back.sv
// ----------------------------------------------------------------------------
// spte_back
// Carries out jobs: serializes an instruction packet one byte a cycle while
// the output is not stalled, or hands on a completion, through an output register.
// ----------------------------------------------------------------------------
module spte_back import spte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  job_t       pop_job,
	output logic       pop_ready,
	spte_rsp_if.source rsp
);

	// packet byte positions
	localparam logic [3:0] BYTE_SYNC_A   = 4'd0;
	localparam logic [3:0] BYTE_SYNC_B   = 4'd1;
	localparam logic [3:0] BYTE_ID       = 4'd2;
	localparam logic [3:0] BYTE_LEN      = 4'd3;
	localparam logic [3:0] BYTE_INSTR    = 4'd4;
	localparam logic [3:0] BYTE_ADDR     = 4'd5;
	localparam logic [3:0] BYTE_VAL_LO   = 4'd6;
	localparam logic [3:0] BYTE_VAL_HI   = 4'd7;
	localparam logic [3:0] BYTE_CHK_TWO  = 4'd8;
	localparam logic [7:0] SYNC_BYTE     = 8'hFF;
	localparam logic [7:0] LEN_ONE_VAL   = 8'd4;
	localparam logic [7:0] LEN_TWO_VAL   = 8'd5;

	job_t        cur_q;
	logic        cur_valid_q;
	logic [3:0]  idx_q;
	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  tx_byte_q;
	logic        tx_last_q;
	logic [1:0]  status_q;
	logic [15:0] read_value_q;
	logic [7:0]  servo_error_q;

	logic        can_load;
	logic [3:0]  last_idx;
	logic        word_last;
	logic [7:0]  sel_byte;

	assign can_load  = !out_valid_q || rsp.ready;
	assign last_idx  = cur_q.two_val ? BYTE_CHK_TWO : BYTE_VAL_HI;
	assign word_last = (cur_q.kind == KIND_DONE) || (idx_q == last_idx);
	assign pop_ready = !cur_valid_q || (can_load && word_last);

	// packet byte select
	always_comb begin
		unique case (idx_q) inside
			BYTE_SYNC_A, BYTE_SYNC_B: sel_byte = SYNC_BYTE;
			BYTE_ID:                  sel_byte = cur_q.id;
			BYTE_LEN:                 sel_byte = cur_q.two_val ? LEN_TWO_VAL : LEN_ONE_VAL;
			BYTE_INSTR:               sel_byte = cur_q.instr;
			BYTE_ADDR:                sel_byte = cur_q.addr;
			BYTE_VAL_LO:              sel_byte = cur_q.value[7:0];
			BYTE_VAL_HI:              sel_byte = cur_q.two_val ? cur_q.value[15:8] : cur_q.chk;
			BYTE_CHK_TWO:             sel_byte = cur_q.chk;
			default:                  sel_byte = 8'd0;
		endcase
	end

	// current job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 4'd0;
		end else if (pop_valid && pop_ready) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 4'd0;
		end else if (cur_valid_q && can_load) begin
			if (word_last)
				cur_valid_q <= 1'b0;
			else
				idx_q <= idx_q + 4'd1;
		end
	end

	// current job payload
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready)
			cur_q <= pop_job;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (can_load)
			out_valid_q <= cur_valid_q;
	end

	// output register word
	always_ff @(posedge clk) begin
		if (can_load && cur_valid_q) begin
			out_kind_q <= cur_q.kind;
			if (cur_q.kind == KIND_TX) begin
				tx_byte_q     <= sel_byte;
				tx_last_q     <= word_last;
				status_q      <= ST_OK;
				read_value_q  <= 16'd0;
				servo_error_q <= 8'd0;
			end else begin
				tx_byte_q     <= 8'd0;
				tx_last_q     <= 1'b0;
				status_q      <= cur_q.status;
				read_value_q  <= cur_q.read_value;
				servo_error_q <= cur_q.servo_error;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_kind    = out_kind_q;
	assign rsp.tx_byte     = tx_byte_q;
	assign rsp.tx_last     = tx_last_q;
	assign rsp.status_code = status_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.servo_error = servo_error_q;

`ifndef NO_ASSERTIONS
	// byte position never runs past the checksum of the packet
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && cur_q.kind == KIND_TX) |-> (idx_q <= last_idx))
		else $error("packet byte position past checksum");
`endif

endmodule

### rtl/servo_packet_transaction_engine.sv
// ----------------------------------------------------------------------------
// servo_packet_transaction_engine
// Master side of a half-duplex servo bus transaction: sends instruction
// packets, tracks the status reply and reports completion or timeout.
// ----------------------------------------------------------------------------
// Throughput: one request word per cycle while the job queue has room; a
//   command gives 8 or 9 transmit words from the back end, one byte each, and
//   up to QUEUE_DEPTH jobs wait between front and back before the input stalls.
// Reset: arst_n clears all control state at once; servo_id returns to 1 and
//   timeout_ticks to 100. No clearing pass is needed.
module servo_packet_transaction_engine import spte_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	spte_req_if.sink   req,
	spte_rsp_if.source rsp,
	spte_cfg_if.sink   cfg
);

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	// accept and classify
	spte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	// job queue
	spte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	// carry out jobs
	spte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule

### tb/sv/tb_servo_packet_transaction_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_packet_transaction_engine
// Self-checking bench for the servo packet transaction engine. A driver feeds
// commands, bus bytes and ticks from a queue. A monitor checks every result
// word against a predicted instruction packet or transaction completion. Both
// sides stall at random, and the register settings change between phases.
// ----------------------------------------------------------------------------
module tb_servo_packet_transaction_engine import spte_pkg::*;;

	localparam logic [1:0] REQ_UNUSED   = 2'd3;
	localparam int         DRAIN_CYCLES = 12;
	localparam int         LONG_HOLD    = 300;
	localparam int         STALL_LIMIT  = 4000;
	localparam int         RANDOM_ITEMS = 100;

	typedef struct {
		logic [1:0]  rtype;
		logic [7:0]  instr;
		logic [7:0]  addr;
		logic [1:0]  nval;
		logic [15:0] value;
		logic [3:0]  rlen;
		logic [7:0]  rxb;
	} bus_req_t;

	typedef struct {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic [1:0]  status;
		logic [15:0] read_value;
		logic [7:0]  servo_error;
	} bus_word_t;

	logic clk = 1'b0;
	logic arst_n;

	spte_req_if req_bus ();
	spte_rsp_if rsp_bus ();
	spte_cfg_if cfg_bus ();

	servo_packet_transaction_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// clock
	always #1 clk = ~clk;

	bus_req_t  pending_reqs[$];
	bus_word_t expected_words[$];
	bus_req_t  drv_item;
	bus_word_t mon_word;

	int n_queued    = 0;
	int n_accepted  = 0;
	int mismatches  = 0;
	int src_gap     = 0;
	int sink_gap    = 0;
	int hold_cnt    = 0;
	int hold_reqs   = 0;
	int hold_done   = 0;
	int quiet_count = 0;
	bit idle_on     = 1'b0;

	// predictor copy of registers and transaction state
	logic [7:0]  cfg_servo_id;
	logic [15:0] cfg_timeout;
	logic        trk_waiting;
	logic [3:0]  trk_rx_count;
	logic [3:0]  trk_exp_count;
	logic [7:0]  trk_err;
	logic [7:0]  trk_data_lo;
	logic [7:0]  trk_data_hi;
	logic [15:0] trk_elapsed;

	// status length after clamping
	function automatic logic [3:0] resp_words(input logic [3:0] rlen);
		if (rlen < RESP_MIN) return RESP_MIN;
		if (rlen > MAX_RESP_BYTES) return MAX_RESP_BYTES;
		return rlen;
	endfunction

	function automatic void push_tx(input logic [7:0] b, input logic last);
		bus_word_t w;
		w.kind        = KIND_TX;
		w.tx_byte     = b;
		w.tx_last     = last;
		w.status      = ST_OK;
		w.read_value  = 16'd0;
		w.servo_error = 8'd0;
		expected_words.push_back(w);
	endfunction

	function automatic void push_done(input logic [1:0] code);
		bus_word_t w;
		w.kind        = KIND_DONE;
		w.tx_byte     = 8'd0;
		w.tx_last     = 1'b0;
		w.status      = code;
		w.read_value  = {trk_data_hi, trk_data_lo};
		w.servo_error = trk_err;
		trk_waiting   = 1'b0;
		expected_words.push_back(w);
	endfunction

	// expected result words for one accepted request word
	function automatic void predict_engine_words(input bus_req_t it);
		logic       two;
		logic [7:0] lenb;
		logic [7:0] csum;
		two  = (it.nval >= 2'd2);
		lenb = two ? 8'd5 : 8'd4;
		if (it.rtype == REQ_CMD) begin
			csum = cfg_servo_id + lenb + it.instr + it.addr + it.value[7:0];
			if (two) csum = csum + it.value[15:8];
			push_tx(8'hFF, 1'b0);
			push_tx(8'hFF, 1'b0);
			push_tx(cfg_servo_id, 1'b0);
			push_tx(lenb, 1'b0);
			push_tx(it.instr, 1'b0);
			push_tx(it.addr, 1'b0);
			push_tx(it.value[7:0], 1'b0);
			if (two) push_tx(it.value[15:8], 1'b0);
			push_tx(~csum, 1'b1);
			trk_waiting   = 1'b1;
			trk_rx_count  = 4'd0;
			trk_exp_count = resp_words(it.rlen);
			trk_err       = 8'd0;
			trk_data_lo   = 8'd0;
			trk_data_hi   = 8'd0;
			trk_elapsed   = 16'd0;
		end else if (trk_waiting && it.rtype == REQ_RX) begin
			case (trk_rx_count)
				4'd4: trk_err = it.rxb;
				4'd5: trk_data_lo = it.rxb;
				4'd6: trk_data_hi = it.rxb;
				default: ;
			endcase
			trk_rx_count = trk_rx_count + 4'd1;
			if (trk_rx_count >= trk_exp_count)
				push_done((trk_err != 8'd0) ? ST_SERVO_ERR : ST_OK);
		end else if (trk_waiting && it.rtype == REQ_TICK) begin
			if (trk_elapsed != 16'hFFFF) trk_elapsed = trk_elapsed + 16'd1;
			if (trk_elapsed > cfg_timeout) push_done(ST_TIMEOUT);
		end
	endfunction

	// driver: request words from the pending queue
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				predict_engine_words(drv_item);
				n_accepted++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					req_bus.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					drv_item = pending_reqs.pop_front();
					req_bus.valid       <= 1'b1;
					req_bus.req_type    <= drv_item.rtype;
					req_bus.instr_code  <= drv_item.instr;
					req_bus.reg_addr    <= drv_item.addr;
					req_bus.value_bytes <= drv_item.nval;
					req_bus.param_value <= drv_item.value;
					req_bus.resp_len    <= drv_item.rlen;
					req_bus.rx_byte     <= drv_item.rxb;
					if (idle_on && $urandom_range(0, 9) == 0)
						src_gap = $urandom_range(1, 19);
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check result words, drive ready with stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: kind %0d tx %h last %0d st %0d rd %h err %h",
							rsp_bus.out_kind, rsp_bus.tx_byte, rsp_bus.tx_last,
							rsp_bus.status_code, rsp_bus.read_value, rsp_bus.servo_error);
				end else begin
					mon_word = expected_words.pop_front();
					if (rsp_bus.out_kind !== mon_word.kind ||
					    rsp_bus.tx_byte !== mon_word.tx_byte ||
					    rsp_bus.tx_last !== mon_word.tx_last ||
					    rsp_bus.status_code !== mon_word.status ||
					    rsp_bus.read_value !== mon_word.read_value ||
					    rsp_bus.servo_error !== mon_word.servo_error) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp kind %0d tx %h last %0d st %0d rd %h err %h",
								mon_word.kind, mon_word.tx_byte, mon_word.tx_last,
								mon_word.status, mon_word.read_value, mon_word.servo_error);
							$display("          got kind %0d tx %h last %0d st %0d rd %h err %h",
								rsp_bus.out_kind, rsp_bus.tx_byte, rsp_bus.tx_last,
								rsp_bus.status_code, rsp_bus.read_value, rsp_bus.servo_error);
						end
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_bus.ready <= 1'b0;
			end else if (hold_reqs != hold_done) begin
				hold_done++;
				hold_cnt = LONG_HOLD;
				rsp_bus.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					sink_gap = $urandom_range(1, 19);
			end
		end
	end

	// watchdog on cycles with no accepted word anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
			    (cfg_bus.valid && cfg_bus.ready))
				quiet_count = 0;
			else
				quiet_count++;
			if (quiet_count >= STALL_LIMIT) begin
				$display("tb_servo_packet_transaction_engine: done, errors");
				$finish;
			end
		end
	end

	function automatic bus_req_t rand_req();
		bus_req_t r;
		r.rtype = $urandom_range(0, 3);
		r.instr = $urandom_range(0, 255);
		r.addr  = $urandom_range(0, 255);
		r.nval  = $urandom_range(0, 3);
		r.value = $urandom_range(0, 65535);
		r.rlen  = $urandom_range(0, 15);
		r.rxb   = $urandom_range(0, 255);
		return r;
	endfunction

	task automatic send(input bus_req_t r);
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	task automatic send_cmd(input logic [7:0] instr, input logic [7:0] addr,
	                        input logic [1:0] nval, input logic [15:0] value,
	                        input logic [3:0] rlen);
		bus_req_t r;
		r       = rand_req();
		r.rtype = REQ_CMD;
		r.instr = instr;
		r.addr  = addr;
		r.nval  = nval;
		r.value = value;
		r.rlen  = rlen;
		send(r);
	endtask

	task automatic send_kind(input logic [1:0] rtype, input logic [7:0] b);
		bus_req_t r;
		r       = rand_req();
		r.rtype = rtype;
		r.rxb   = b;
		send(r);
	endtask

	// first n bytes of a status packet, with ticks mixed in
	task automatic send_status(input int n, input logic [7:0] err,
	                           input logic [15:0] data, input int tick_pct);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < tick_pct) send_kind(REQ_TICK, 8'd0);
			case (i)
				0, 1: b = 8'hFF;
				4: b = err;
				5: b = data[7:0];
				6: b = data[15:8];
				default: b = $urandom_range(0, 255);
			endcase
			send_kind(REQ_RX, b);
		end
	endtask

	task automatic wait_idle();
		while (n_queued != n_accepted || expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_SERVO_ID) cfg_servo_id = data[7:0];
		else cfg_timeout = data;
	endtask

	initial begin
		int         start;
		int         txn;
		int         kind;
		int         n;
		logic [3:0] rlen;
		logic [7:0] err;

		// known values before the first edge
		arst_n              = 1'b0;
		req_bus.valid       = 1'b0;
		req_bus.req_type    = REQ_TICK;
		req_bus.instr_code  = 8'd0;
		req_bus.reg_addr    = 8'd0;
		req_bus.value_bytes = 2'd1;
		req_bus.param_value = 16'd0;
		req_bus.resp_len    = RESP_MIN;
		req_bus.rx_byte     = 8'd0;
		rsp_bus.ready       = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = REG_SERVO_ID;
		cfg_bus.data        = 16'd0;

		cfg_servo_id  = SERVO_ID_RST;
		cfg_timeout   = TIMEOUT_RST;
		trk_waiting   = 1'b0;
		trk_rx_count  = 4'd0;
		trk_exp_count = 4'd0;
		trk_err       = 8'd0;
		trk_data_lo   = 8'd0;
		trk_data_hi   = 8'd0;
		trk_elapsed   = 16'd0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// idle requests are dropped, then a clean write at reset settings
		send_kind(REQ_RX, 8'hA5);
		send_kind(REQ_TICK, 8'h00);
		send_kind(REQ_UNUSED, 8'hFF);
		send_cmd(8'h03, 8'h1E, 2'd2, 16'hFFFF, 4'd6);
		send_status(6, 8'h00, 16'h0000, 0);
		wait_idle();

		// zero limit times out on the first tick, short count and length
		write_reg(REG_SERVO_ID, 16'h0000);
		write_reg(REG_TIMEOUT_TICKS, 16'h0000);
		send_cmd(8'h00, 8'h00, 2'd0, 16'h0000, 4'd0);
		send_kind(REQ_TICK, 8'h00);
		wait_idle();

		// top id, long reply clamped, servo error with data
		write_reg(REG_SERVO_ID, 16'hFFFF);
		write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
		send_cmd(8'hFF, 8'hFF, 2'd3, 16'hA55A, 4'd15);
		send_status(8, 8'h20, 16'hBEEF, 0);
		wait_idle();

		// command while waiting restarts the transaction
		write_reg(REG_SERVO_ID, 16'h00FD);
		write_reg(REG_TIMEOUT_TICKS, 16'd3);
		send_cmd(8'h02, 8'h24, 2'd1, 16'h0002, 4'd7);
		send_status(3, 8'h00, 16'h0000, 0);
		send_cmd(8'h03, 8'h20, 2'd2, 16'h0200, 4'd6);
		send_status(6, 8'h00, 16'h1234, 0);
		wait_idle();

		// random transactions with stalls on both sides
		idle_on = 1'b1;
		start   = n_queued;
		txn     = 0;
		while (n_queued - start < RANDOM_ITEMS) begin
			if (txn % 4 == 3) begin
				wait_idle();
				write_reg(REG_SERVO_ID, $urandom_range(0, 65535));
				if ($urandom_range(0, 4) == 0)
					write_reg(REG_TIMEOUT_TICKS, $urandom_range(0, 65535));
				else
					write_reg(REG_TIMEOUT_TICKS, $urandom_range(0, 10));
			end
			if (txn == 6) begin
				// long receiver hold while commands keep coming
				hold_reqs++;
				for (int i = 0; i < 10; i++)
					send_cmd($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 3), $urandom_range(0, 65535), RESP_MIN);
				send_status(6, 8'h00, $urandom_range(0, 65535), 0);
				wait_idle();
			end
			kind = $urandom_range(0, 9);
			rlen = ($urandom_range(0, 3) != 0) ? $urandom_range(6, 8) : $urandom_range(0, 15);
			err  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 255) : 8'd0;
			if (kind <= 7)
				send_cmd(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				                                      : $urandom_range(2, 3),
					$urandom_range(0, 255), $urandom_range(0, 3),
					$urandom_range(0, 65535), rlen);
			if (kind <= 5) begin
				send_status(resp_words(rlen), err, $urandom_range(0, 65535), 15);
			end else if (kind == 6) begin
				n = (cfg_timeout < 20) ? cfg_timeout + 1 + $urandom_range(0, 1)
				                       : $urandom_range(1, 5);
				for (int i = 0; i < n; i++) send_kind(REQ_TICK, 8'd0);
			end else if (kind == 7) begin
				send_status($urandom_range(1, resp_words(rlen) - 1), err,
					$urandom_range(0, 65535), 20);
			end else if (kind == 8) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) send(rand_req());
			end else begin
				// sender pause until every result is back
				wait_idle();
			end
			txn++;
		end
		wait_idle();

		// last part without idling: ticks stay under the top limit
		idle_on = 1'b0;
		write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
		send_cmd(8'h02, 8'h2B, 2'd1, 16'h0002, 4'd8);
		for (int i = 0; i < 12; i++) send_kind(REQ_TICK, 8'd0);
		send_status(8, 8'h00, 16'h5AA5, 0);
		wait_idle();

		if (expected_words.size() != 0) mismatches += expected_words.size();
		if (mismatches == 0) begin
			$display("tb_servo_packet_transaction_engine: done, clean");
		end else begin
			$display("tb_servo_packet_transaction_engine: done, errors");
		end
		$finish;
	end

endmodule
